/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Same check on the local clk / rst_n.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    `ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

/* hw/rtl/lbo_pkg.sv */
package lbo_pkg;

    localparam int COLOR_BITS      = 24;
    localparam int LABEL_IN_BITS   = 16;
    localparam int WIDTH_CFG_BITS  = 11;
    localparam int HEIGHT_CFG_BITS = 16;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 3;

    localparam logic [COLOR_BITS-1:0]      WHITE_RGB    = 24'hFF_FFFF;
    localparam logic [WIDTH_CFG_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_CFG_BITS-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic
    {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // per-item control carried from the address stage to the compare stage
    typedef struct packed
    {
        logic is_flush;
        logic has_result;
        logic need_left;
        logic need_right;
        logic need_up;
        logic eof;
    } lbo_ctl_t;

endpackage

/* hw/rtl/lbo_in_if.sv */
interface lbo_in_if import lbo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [LABEL_IN_BITS-1:0] region_label;
    logic [COLOR_BITS-1:0]    color;

    modport source (output valid, output kind, output region_label, output color,
                    input ready);
    modport sink   (input valid, input kind, input region_label, input color,
                    output ready);
endinterface

/* hw/rtl/lbo_out_if.sv */
interface lbo_out_if import lbo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] color_out;
    logic                  on_boundary;
    logic                  end_of_frame;

    modport source (output valid, output color_out, output on_boundary,
                    output end_of_frame, input ready);
    modport sink   (input valid, input color_out, input on_boundary,
                    input end_of_frame, output ready);
endinterface

/* hw/rtl/lbo_line_buf.sv */
// Line store: one write port, two registered read ports, write-to-read bypass
// when a read and a write of the same entry land on the same edge.
module lbo_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 56
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr0,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr1,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         wr_data,
    output logic [DATA_BITS-1:0]         rd_data0,
    output logic [DATA_BITS-1:0]         rd_data1
);

    logic [DATA_BITS-1:0] ram [DEPTH];
    logic [DATA_BITS-1:0] q0_reg;
    logic [DATA_BITS-1:0] q1_reg;
    logic [DATA_BITS-1:0] byp_data_reg;
    logic                 byp0_reg;
    logic                 byp1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q0_reg       <= ram[rd_addr0];
            q1_reg       <= ram[rd_addr1];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp0_reg <= 1'b0;
            byp1_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp0_reg <= wr_en && (wr_addr == rd_addr0);
            byp1_reg <= wr_en && (wr_addr == rd_addr1);
        end
    end

    assign rd_data0 = byp0_reg ? byp_data_reg : q0_reg;
    assign rd_data1 = byp1_reg ? byp_data_reg : q1_reg;

endmodule

/* hw/rtl/label_boundary_overlay_core.sv */
// The result an input transfer releases passes stage 1 (compare), then the output
// register; pixels come out one row behind, the last row on flush items.
// Throughput: one item per cycle; the input stalls only while stage 1 holds a result
// and the output register is full and not being drained.
// Reset (rst_n, async, active low) clears counters and handshake state and loads
// image_width 640, image_height 480; line store contents stay undefined.
`include "assert_macros.svh"

module label_boundary_overlay_core import lbo_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int LABEL_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    lbo_in_if.sink                   in_ch,
    lbo_out_if.source                out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int CW         = $clog2(MAX_WIDTH);   // column index bits
    localparam int EW         = CW + 1;              // holds MAX_WIDTH itself
    localparam int WCMP       = (EW > WIDTH_CFG_BITS) ? EW : WIDTH_CFG_BITS;
    localparam int ENTRY_BITS = 2 * LABEL_BITS + COLOR_BITS;

    // ------------------------------------------------------------------
    // Configuration registers (APB, zero wait state)
    // ------------------------------------------------------------------
    logic [WIDTH_CFG_BITS-1:0]  image_width_reg;
    logic [HEIGHT_CFG_BITS-1:0] image_height_reg;
    cfg_reg_t                   cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_sel)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_CFG_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HEIGHT_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size: width clamped to 1..MAX_WIDTH, height 0 taken as 1.
    logic [EW-1:0]              eff_w;
    logic [HEIGHT_CFG_BITS-1:0] eff_h;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (WCMP'(image_width_reg) > WCMP'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(image_width_reg);
        end
    end

    assign eff_h = (image_height_reg == '0) ? HEIGHT_CFG_BITS'(1) : image_height_reg;

    // ------------------------------------------------------------------
    // Position counters and stage 0 (address / decide)
    // ------------------------------------------------------------------
    logic [CW-1:0]              column_count_reg, column_count_next;
    logic [HEIGHT_CFG_BITS-1:0] row_count_reg,    row_count_next;
    logic [CW-1:0]              flush_count_reg,  flush_count_next;

    logic [EW-1:0] col_inc;
    logic [EW-1:0] flush_inc;
    logic          frame_done;     // all rows taken in, last row waits for flush
    logic          in_fire;
    logic          in_is_flush;
    logic          load_s1;
    lbo_ctl_t      ctl_in;
    logic [CW-1:0] addr_in;

    assign col_inc     = {1'b0, column_count_reg} + EW'(1);
    assign flush_inc   = {1'b0, flush_count_reg} + EW'(1);
    assign frame_done  = row_count_reg >= eff_h;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_is_flush = (in_ch.kind == KIND_FLUSH);
    assign addr_in     = in_is_flush ? flush_count_reg : column_count_reg;

    // Items that neither write the store nor give a result (pixels past the
    // last row, flushes before it) are taken and dropped here.
    always_comb
    begin
        load_s1           = 1'b0;
        ctl_in            = '0;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        flush_count_next  = flush_count_reg;
        if (in_fire)
        begin
            if (!in_is_flush)
            begin
                if (!frame_done)
                begin
                    load_s1           = 1'b1;
                    ctl_in.has_result = (row_count_reg != '0);
                    ctl_in.need_left  = (column_count_reg != '0);
                    ctl_in.need_right = (col_inc < eff_w);
                    ctl_in.need_up    = (row_count_reg >= HEIGHT_CFG_BITS'(2));
                    if (col_inc >= eff_w)
                    begin
                        column_count_next = '0;
                        row_count_next    = row_count_reg + HEIGHT_CFG_BITS'(1);
                    end
                    else
                    begin
                        column_count_next = col_inc[CW-1:0];
                    end
                end
            end
            else if (frame_done)
            begin
                load_s1           = 1'b1;
                ctl_in.is_flush   = 1'b1;
                ctl_in.has_result = 1'b1;
                ctl_in.need_left  = (flush_count_reg != '0);
                ctl_in.need_right = (flush_inc < eff_w);
                ctl_in.need_up    = (eff_h >= HEIGHT_CFG_BITS'(2));
                if (flush_inc >= eff_w)
                begin
                    // last pixel of the frame: rearm for the next one
                    ctl_in.eof        = 1'b1;
                    flush_count_next  = '0;
                    column_count_next = '0;
                    row_count_next    = '0;
                end
                else
                begin
                    flush_count_next = flush_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            flush_count_reg  <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            flush_count_reg  <= flush_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: entry c = {upper label, middle label, delayed colour}.
    // Ports read column c (centre, up, colour) and c+1 (right neighbour).
    // ------------------------------------------------------------------
    logic                  wr_en;
    logic [ENTRY_BITS-1:0] wr_data;
    logic [ENTRY_BITS-1:0] ent0;
    logic [ENTRY_BITS-1:0] ent1;

    logic                  s1_valid_reg, s1_valid_next;
    lbo_ctl_t              s1_ctl_reg;
    logic [CW-1:0]         s1_addr_reg;
    logic [LABEL_BITS-1:0] s1_lab_reg;
    logic [COLOR_BITS-1:0] s1_col_reg;
    logic                  s1_go;

    lbo_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (ENTRY_BITS)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (load_s1),
        .rd_addr0 (addr_in),
        .rd_addr1 (addr_in + CW'(1)),
        .wr_en    (wr_en),
        .wr_addr  (s1_addr_reg),
        .wr_data  (wr_data),
        .rd_data0 (ent0),
        .rd_data1 (ent1)
    );

    // ------------------------------------------------------------------
    // Stage 1: neighbour compare, write back, hand to output register
    // ------------------------------------------------------------------
    logic [LABEL_BITS-1:0] centre;
    logic [LABEL_BITS-1:0] up_lab;
    logic [LABEL_BITS-1:0] right_lab;
    logic [LABEL_BITS-1:0] left_lab;
    logic                  bnd;
    // Left neighbour never comes from the store: for a pixel it is the centre
    // of the pixel just before in the row; for a flush, the centre of the
    // previous flush, patched by any pixel write to that column in between.
    logic [LABEL_BITS-1:0] pix_left_reg;
    logic [LABEL_BITS-1:0] flush_left_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_bnd_reg;
    logic                  out_eof_reg;

    assign centre    = ent0[LABEL_BITS+COLOR_BITS-1:COLOR_BITS];
    assign up_lab    = ent0[ENTRY_BITS-1:LABEL_BITS+COLOR_BITS];
    assign right_lab = ent1[LABEL_BITS+COLOR_BITS-1:COLOR_BITS];
    assign left_lab  = s1_ctl_reg.is_flush ? flush_left_reg : pix_left_reg;

    assign bnd = (s1_ctl_reg.need_left  && (left_lab  != centre))
              || (s1_ctl_reg.need_right && (right_lab != centre))
              || (s1_ctl_reg.need_up    && (up_lab    != centre))
              || (!s1_ctl_reg.is_flush  && (s1_lab_reg != centre));

    // stage 1 moves on unless it holds a result and the output slot stays full
    assign s1_go = s1_valid_reg
                && (!s1_ctl_reg.has_result || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_go;

    // pixel shifts the column: middle becomes upper, new label becomes middle
    assign wr_en   = s1_go && !s1_ctl_reg.is_flush;
    assign wr_data = {centre, s1_lab_reg, s1_col_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load_s1)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (load_s1)
            begin
                s1_ctl_reg <= ctl_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_addr_reg <= addr_in;
            s1_lab_reg  <= LABEL_BITS'(in_ch.region_label);
            s1_col_reg  <= in_ch.color;
        end
        if (wr_en)
        begin
            pix_left_reg <= centre;
        end
        if (s1_go && s1_ctl_reg.is_flush)
        begin
            flush_left_reg <= centre;
        end
        else if (wr_en && (s1_addr_reg == flush_count_reg - CW'(1)))
        begin
            flush_left_reg <= s1_lab_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_ctl_reg.has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_ctl_reg.has_result)
        begin
            out_color_reg <= bnd ? WHITE_RGB : ent0[COLOR_BITS-1:0];
            out_bnd_reg   <= bnd;
            out_eof_reg   <= s1_ctl_reg.eof;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.color_out    = out_color_reg;
    assign out_ch.on_boundary  = out_bnd_reg;
    assign out_ch.end_of_frame = out_eof_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic early_flush;

    assign early_flush = in_fire && in_is_flush && !frame_done;

    `ASSERT_ALWAYS(a_ready_frees_stage, (in_ch.ready && s1_valid_reg) |-> s1_go, "stage 1 held")
    `ASSERT_ALWAYS(a_result_lands, (s1_go && s1_ctl_reg.has_result) |=> out_valid_reg, "no result")
    `ASSERT_ALWAYS(a_early_flush_dropped, early_flush |=> !s1_valid_reg, "flush kept")

endmodule

/* tb/label_boundary_overlay_core_test.sv */
module label_boundary_overlay_core_test import lbo_pkg::*; ();

    localparam int LINE_MAX    = 1024;  // line store depth, same as the core default
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off used once for back-pressure
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up

    // One output pixel as it leaves the core.
    typedef struct packed
    {
        logic [COLOR_BITS-1:0] color_out;
        logic                  on_boundary;
        logic                  end_of_frame;
    } overlay_px_t;

    // How a queued input item is checked: by the predictor, as producing nothing,
    // or against the result typed into the row.
    typedef enum logic [1:0]
    {
        BY_MODEL  = 2'd0,
        NO_OUTPUT = 2'd1,
        OUTPUT_IS = 2'd2
    } row_check_t;

    typedef struct packed
    {
        kind_t                    kind;
        logic [LABEL_IN_BITS-1:0] label;
        logic [COLOR_BITS-1:0]    color;
        row_check_t               check;
        overlay_px_t              typed;
    } stim_t;

    localparam overlay_px_t NO_PX = '0;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    lbo_in_if  in_ch ();
    lbo_out_if out_ch ();

    label_boundary_overlay_core #(
        .MAX_WIDTH  (LINE_MAX),
        .LABEL_BITS (LABEL_IN_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the line store, counters and registers
    // ------------------------------------------------------------------
    logic [LABEL_IN_BITS-1:0]   upper_labels  [LINE_MAX];
    logic [LABEL_IN_BITS-1:0]   middle_labels [LINE_MAX];
    logic [COLOR_BITS-1:0]      held_colors   [LINE_MAX];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                flush_pos;
    logic [WIDTH_CFG_BITS-1:0]  cfg_width;
    logic [HEIGHT_CFG_BITS-1:0] cfg_height;

    stim_t       stim_q[$];      // waiting to be offered
    stim_t       driven_q[$];    // on the bus or offered, in transfer order
    overlay_px_t expected_q[$];  // overlay pixels still owed by the core

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int holds_done    = 0;

    // Directed rows. Frame 1 is 3x2 with one flat label, so every result is just
    // the colour from a row earlier; frame 2 mixes the extreme labels and is left
    // to the predictor.
    stim_t directed_rows [21] = '{
        // flush before any row of the frame is in: dropped
        {KIND_FLUSH, 16'h0000, 24'h000000, NO_OUTPUT, NO_PX},
        // row zero: nothing comes out yet
        {KIND_PIXEL, 16'h0000, 24'h000000, NO_OUTPUT, NO_PX},
        {KIND_PIXEL, 16'h0000, 24'hFFFFFF, NO_OUTPUT, NO_PX},
        {KIND_PIXEL, 16'h0000, 24'h5A5A5A, NO_OUTPUT, NO_PX},
        {KIND_FLUSH, 16'hFFFF, 24'hFFFFFF, NO_OUTPUT, NO_PX},
        // row one emits row zero, flat label so colours pass through
        {KIND_PIXEL, 16'h0000, 24'hA5A5A5, OUTPUT_IS, {24'h000000, 1'b0, 1'b0}},
        {KIND_PIXEL, 16'h0000, 24'h0F0F0F, OUTPUT_IS, {24'hFFFFFF, 1'b0, 1'b0}},
        {KIND_PIXEL, 16'h0000, 24'hF0F0F0, OUTPUT_IS, {24'h5A5A5A, 1'b0, 1'b0}},
        // frame is full: extra pixel dropped until flushed
        {KIND_PIXEL, 16'hFFFF, 24'h123456, NO_OUTPUT, NO_PX},
        // flushes emit the last row, end of frame on the final one
        {KIND_FLUSH, 16'h0000, 24'h000000, OUTPUT_IS, {24'hA5A5A5, 1'b0, 1'b0}},
        {KIND_FLUSH, 16'h0000, 24'h000000, OUTPUT_IS, {24'h0F0F0F, 1'b0, 1'b0}},
        {KIND_FLUSH, 16'h0000, 24'h000000, OUTPUT_IS, {24'hF0F0F0, 1'b0, 1'b1}},
        // new frame right after the end of flush, extreme labels
        {KIND_PIXEL, 16'hFFFF, 24'h000000, NO_OUTPUT, NO_PX},
        {KIND_PIXEL, 16'h0000, 24'hFFFFFF, NO_OUTPUT, NO_PX},
        {KIND_PIXEL, 16'hFFFF, 24'h00FF00, NO_OUTPUT, NO_PX},
        {KIND_PIXEL, 16'hFFFF, 24'hFF0000, BY_MODEL,  NO_PX},
        {KIND_PIXEL, 16'hFFFF, 24'h0000FF, BY_MODEL,  NO_PX},
        {KIND_PIXEL, 16'hFFFF, 24'h808080, BY_MODEL,  NO_PX},
        {KIND_FLUSH, 16'h0000, 24'h000000, BY_MODEL,  NO_PX},
        {KIND_FLUSH, 16'hFFFF, 24'hFFFFFF, BY_MODEL,  NO_PX},
        {KIND_FLUSH, 16'h0000, 24'h000000, BY_MODEL,  NO_PX}
    };

    // Works out the overlay pixel an accepted item releases, if any, and
    // advances the predictor's line store and counters.
    function automatic bit predict_overlay(input stim_t st, output overlay_px_t px);
        int unsigned              w;
        int unsigned              h;
        int unsigned              c;
        logic [LABEL_IN_BITS-1:0] centre;
        logic                     marked;
        bit                       emits;
        w      = (cfg_width == 0) ? 1 : ((cfg_width > LINE_MAX) ? LINE_MAX : cfg_width);
        h      = (cfg_height == 0) ? 1 : cfg_height;
        px     = '0;
        marked = 1'b0;
        if (st.kind == KIND_PIXEL)
        begin
            if (row_pos >= h)
                return 1'b0;
            c     = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
            emits = (row_pos >= 1);
            if (emits)
            begin
                // centre is the pixel one row up; the left neighbour has already
                // moved into the upper row, the right one is still in the middle row
                centre = middle_labels[c];
                if (c > 0 && upper_labels[c - 1] != centre)
                    marked = 1'b1;
                if (c + 1 < w && middle_labels[c + 1] != centre)
                    marked = 1'b1;
                if (row_pos >= 2 && upper_labels[c] != centre)
                    marked = 1'b1;
                if (st.label != centre)
                    marked = 1'b1;
                px.color_out   = marked ? WHITE_RGB : held_colors[c];
                px.on_boundary = marked;
            end
            upper_labels[c]  = middle_labels[c];
            middle_labels[c] = st.label;
            held_colors[c]   = st.color;
            if (col_pos + 1 >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            else
                col_pos++;
            return emits;
        end
        // flush: only once the last row is in; no neighbour below
        if (row_pos < h)
            return 1'b0;
        c      = (flush_pos >= LINE_MAX) ? LINE_MAX - 1 : flush_pos;
        centre = middle_labels[c];
        if (c > 0 && middle_labels[c - 1] != centre)
            marked = 1'b1;
        if (c + 1 < w && middle_labels[c + 1] != centre)
            marked = 1'b1;
        if (h >= 2 && upper_labels[c] != centre)
            marked = 1'b1;
        px.color_out   = marked ? WHITE_RGB : held_colors[c];
        px.on_boundary = marked;
        if (flush_pos + 1 >= w)
        begin
            px.end_of_frame = 1'b1;
            flush_pos       = 0;
            col_pos         = 0;
            row_pos         = 0;
        end
        else
            flush_pos++;
        return 1'b1;
    endfunction

    function automatic void report_field(input string field, input logic [23:0] want,
                                         input logic [23:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        fail_count++;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input side: offers queued items, honoring the random idle rate.
    // valid only drops after a transfer, never while an item waits.
    // ------------------------------------------------------------------
    initial
    begin
        stim_t nxt;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_PIXEL;
        in_ch.region_label = '0;
        in_ch.color        = '0;
        forever
        begin
            @(posedge clk);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (stim_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = stim_q.pop_front();
                    driven_q.push_back(nxt);
                    in_ch.valid        <= 1'b1;
                    in_ch.kind         <= nxt.kind;
                    in_ch.region_label <= nxt.label;
                    in_ch.color        <= nxt.color;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off on request that is
    // counted out here so the core fills up and back-pressures its input.
    // ------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every input transfer, then checks every output
    // transfer against the oldest pixel owed. Prediction comes first so a
    // same-edge pair can never be seen out of order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stim_t       taken;
        overlay_px_t due;
        overlay_px_t want;
        logic        emits;
        logic        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                moved = 1'b1;
                taken = driven_q.pop_front();
                emits = predict_overlay(taken, due);
                case (taken.check)
                    BY_MODEL:  if (emits) expected_q.push_back(due);
                    OUTPUT_IS: expected_q.push_back(taken.typed);
                    default:   ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                moved = 1'b1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %b %b",
                             $time, out_ch.color_out, out_ch.on_boundary, out_ch.end_of_frame);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.color_out !== want.color_out)
                        report_field("color_out", want.color_out, out_ch.color_out);
                    if (out_ch.on_boundary !== want.on_boundary)
                        report_field("on_boundary", 24'(want.on_boundary),
                                     24'(out_ch.on_boundary));
                    if (out_ch.end_of_frame !== want.end_of_frame)
                        report_field("end_of_frame", 24'(want.end_of_frame),
                                     24'(out_ch.end_of_frame));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: nothing has moved for too long.
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[label_boundary_overlay_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input kind_t kind, input logic [LABEL_IN_BITS-1:0] label,
                              input logic [COLOR_BITS-1:0] color);
        stim_t st;
        st       = '0;
        st.kind  = kind;
        st.label = label;
        st.color = color;
        st.check = BY_MODEL;
        stim_q.push_back(st);
    endtask

    // One well-formed frame of w x h: four label regions split at a random
    // row and column, some label noise, an occasional early flush and
    // occasional surplus pixels after the last row (both dropped by the core).
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               inout int unsigned useful);
        logic [LABEL_IN_BITS-1:0] palette [4];
        logic [LABEL_IN_BITS-1:0] lab;
        int unsigned              split_col;
        int unsigned              split_row;
        for (int i = 0; i < 4; i++)
            palette[i] = LABEL_IN_BITS'($urandom_range(0, 16'hFFFF));
        split_col = $urandom_range(0, w);
        split_row = $urandom_range(0, h);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                if ($urandom_range(0, 39) == 0)
                    queue_item(KIND_FLUSH, LABEL_IN_BITS'($urandom_range(0, 16'hFFFF)),
                               COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
                if ($urandom_range(0, 9) == 0)
                    lab = LABEL_IN_BITS'($urandom_range(0, 16'hFFFF));
                else
                    lab = palette[(c >= split_col) + 2 * (r >= split_row)];
                queue_item(KIND_PIXEL, lab, COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
            end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                queue_item(KIND_PIXEL, LABEL_IN_BITS'($urandom_range(0, 16'hFFFF)),
                           COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
        for (int c = 0; c < w; c++)
            queue_item(KIND_FLUSH, LABEL_IN_BITS'($urandom_range(0, 16'hFFFF)),
                       COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
        useful += (h + 1) * w;
    endtask

    // APB write, then read back; also updates the predictor's register copy.
    task automatic set_register(input cfg_reg_t idx, input logic [APB_DATA_BITS-1:0] value);
        logic [APB_DATA_BITS-1:0] mask;
        logic [APB_DATA_BITS-1:0] readback;
        mask = (idx == REG_IMAGE_WIDTH) ? (32'd1 << WIDTH_CFG_BITS) - 1
                                        : (32'd1 << HEIGHT_CFG_BITS) - 1;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cfg_width = value[WIDTH_CFG_BITS-1:0];
        else
            cfg_height = value[HEIGHT_CFG_BITS-1:0];
        if ((readback & mask) !== (value & mask))
        begin
            $display("%0t: register %s readback mismatch, expected %h, actual %h",
                     $time, idx.name(), value & mask, readback & mask);
            fail_count++;
        end
    endtask

    // Everything offered and transferred, nothing owed, then a further wait, since an item
    // that gives no result can still be in stage 1 when the last result leaves.
    task automatic wait_until_idle();
        while (stim_q.size() != 0 || driven_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned useful;
        int unsigned w_reg;
        int unsigned h_reg;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        col_pos    = 0;
        row_pos    = 0;
        flush_pos  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on a 3x2 image, no idling
        set_register(REG_IMAGE_WIDTH, 3);
        set_register(REG_IMAGE_HEIGHT, 2);
        foreach (directed_rows[i])
            stim_q.push_back(directed_rows[i]);
        wait_until_idle();

        // tallest setting on a one-pixel column, cut short by lowering the
        // height to where the row counter already stands
        set_register(REG_IMAGE_WIDTH, 0);
        set_register(REG_IMAGE_HEIGHT, 16'hFFFF);
        for (int r = 0; r < 40; r++)
            queue_item(KIND_PIXEL, $urandom_range(0, 1) ? 16'h0000 : 16'h8000,
                       COLOR_BITS'($urandom_range(0, 24'hFFFFFF)));
        wait_until_idle();
        set_register(REG_IMAGE_HEIGHT, 40);
        queue_item(KIND_FLUSH, 16'h0000, 24'h000000);
        wait_until_idle();

        // random frames: a fresh size per phase, idle mode cycling through
        // none, sender idle, receiver stall, both
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 86;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 86;
                end
                default:
                begin
                    tx_idle_pct  = 9;
                    rx_stall_pct = 9;
                end
            endcase
            w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h_reg = $urandom_range(0, 6);
            set_register(REG_IMAGE_WIDTH, w_reg);
            set_register(REG_IMAGE_HEIGHT, h_reg);
            if (ph == 6)
            begin
                // receiver holds off while the sender keeps offering
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
                hold_requests++;
            end
            useful = 0;
            while (useful < 60)
                queue_frame(w_reg, (h_reg == 0) ? 1 : h_reg, useful);
            wait_until_idle();
        end

        if (fail_count == 0)
            $display("[label_boundary_overlay_core] OK");
        else
            $display("[label_boundary_overlay_core] ERROR");
        $finish;
    end

endmodule

/* label_boundary_overlay_core.f */
+incdir+hw/rtl
hw/rtl/lbo_pkg.sv
hw/rtl/lbo_in_if.sv
hw/rtl/lbo_out_if.sv
hw/rtl/lbo_line_buf.sv
hw/rtl/label_boundary_overlay_core.sv
tb/label_boundary_overlay_core_test.sv
